>>> hw/rtl/tpaf_pkg.sv
package tpaf_pkg;

	localparam int NUM_CHANNELS = 5;
	localparam int CH_W         = 3;
	localparam int DATA_W       = 16;
	localparam int OUT_W        = 5;
	localparam int CFG_IDX_W    = 2;

	localparam logic [1:0] CMD_TICK       = 2'd0;
	localparam logic [1:0] CMD_ZERO_CROSS = 2'd1;
	localparam logic [1:0] CMD_SET_DELAY  = 2'd2;
	localparam logic [1:0] CMD_SET_RUN    = 2'd3;

	localparam logic [CFG_IDX_W-1:0] REG_LOW_LIMIT   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HIGH_LIMIT  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_PULSE_WIDTH = 2'd2;

	localparam logic [DATA_W-1:0] LOW_LIMIT_RST   = 16'd100;
	localparam logic [DATA_W-1:0] HIGH_LIMIT_RST  = 16'd10000;
	localparam logic [DATA_W-1:0] PULSE_WIDTH_RST = 16'd100;
	localparam logic [DATA_W-1:0] COUNT_MAX       = {DATA_W{1'b1}};

	typedef struct packed {
		logic tick;
		logic zero_cross;
		logic set_delay;
		logic set_run;
	} lane_ctl_t;

	typedef struct packed {
		logic [OUT_W-1:0] gate_bits;
		logic [OUT_W-1:0] fired_bits;
	} result_t;

endpackage

>>> hw/rtl/tpaf_lane.sv
module tpaf_lane (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  tpaf_pkg::lane_ctl_t           ctl,
	input  logic                          addressed,
	input  logic [tpaf_pkg::DATA_W-1:0]   delay_in,
	input  logic                          run_in,
	input  logic [tpaf_pkg::DATA_W-1:0]   high_limit,
	input  logic [tpaf_pkg::DATA_W-1:0]   pulse_width,
	output logic                          gate,
	output logic                          fired
);

	logic                        run_q, run_n;
	logic                        armed_q, armed_n;
	logic [tpaf_pkg::DATA_W-1:0] delay_q, delay_n;
	logic [tpaf_pkg::DATA_W-1:0] dcount_q, dcount_n;
	logic [tpaf_pkg::DATA_W-1:0] pcount_q, pcount_n;
	logic [tpaf_pkg::DATA_W-1:0] dcount_inc;
	logic [tpaf_pkg::DATA_W-1:0] pcount_dec;

	assign dcount_inc = (dcount_q != tpaf_pkg::COUNT_MAX) ? dcount_q + 1'b1 : dcount_q;
	assign pcount_dec = (pcount_q != '0) ? pcount_q - 1'b1 : pcount_q;

	always_comb begin
		run_n    = run_q;
		armed_n  = armed_q;
		delay_n  = delay_q;
		dcount_n = dcount_q;
		pcount_n = pcount_q;
		fired    = 1'b0;
		if (ctl.tick) begin
			pcount_n = pcount_dec;
			if (armed_q) begin
				dcount_n = dcount_inc;
				if (dcount_inc >= delay_q) begin
					armed_n  = 1'b0;
					pcount_n = pulse_width;
					fired    = 1'b1;
				end
			end
		end
		if (ctl.zero_cross) begin
			pcount_n = '0;
			if (run_q && (delay_q < high_limit)) begin
				armed_n  = 1'b1;
				dcount_n = '0;
			end
		end
		if (ctl.set_delay && addressed) begin
			delay_n = delay_in;
		end
		if (ctl.set_run && addressed) begin
			run_n    = run_in;
			pcount_n = '0;
		end
	end

	assign gate = (pcount_n != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q    <= 1'b0;
			armed_q  <= 1'b0;
			delay_q  <= '0;
			dcount_q <= '0;
			pcount_q <= '0;
		end else if (en) begin
			run_q    <= run_n;
			armed_q  <= armed_n;
			delay_q  <= delay_n;
			dcount_q <= dcount_n;
			pcount_q <= pcount_n;
		end
	end

endmodule

>>> hw/rtl/tpaf_result_reg.sv
module tpaf_result_reg (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 load,
	input  tpaf_pkg::result_t    result_in,
	output logic                 free,
	output logic                 res_valid,
	input  logic                 res_ready,
	output tpaf_pkg::result_t    result_out
);

	logic              valid_q;
	tpaf_pkg::result_t result_q;

	assign free       = !valid_q || res_ready;
	assign res_valid  = valid_q;
	assign result_out = result_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (free) begin
			valid_q <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (free && load) begin
			result_q <= result_in;
		end
	end

endmodule

>>> hw/rtl/triac_phase_angle_firing.sv
// Channel   Signals                                    Direction
// request   req_valid, req_ready, cmd, channel,        in
//           value, ac_level
// result    res_valid, res_ready, gate_bits,           out
//           fired_bits
// config    cfg_we, cfg_index, cfg_data                in
//
// Each request passes from acceptance to its result through the input register,
// then through the channel update into the result register.
// One request is accepted every cycle while results are taken.
// A stalled result holds the result register, and the input register then fills.
// Reset is asynchronous and puts every channel at rest with the default limits.
module triac_phase_angle_firing (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              req_valid,
	output logic                              req_ready,
	input  logic [1:0]                        cmd,
	input  logic [tpaf_pkg::CH_W-1:0]         channel,
	input  logic [tpaf_pkg::DATA_W-1:0]       value,
	input  logic                              ac_level,
	output logic                              res_valid,
	input  logic                              res_ready,
	output logic [tpaf_pkg::OUT_W-1:0]        gate_bits,
	output logic [tpaf_pkg::OUT_W-1:0]        fired_bits,
	input  logic                              cfg_we,
	input  logic [tpaf_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [tpaf_pkg::DATA_W-1:0]       cfg_data
);

	logic [tpaf_pkg::DATA_W-1:0] low_limit_q, high_limit_q, pulse_width_q;

	logic                        valid_s1;
	logic [1:0]                  cmd_s1;
	logic [tpaf_pkg::CH_W-1:0]   channel_s1;
	logic [tpaf_pkg::DATA_W-1:0] value_s1;
	logic                        ac_level_s1;

	logic                        free;
	logic                        advance;
	tpaf_pkg::lane_ctl_t         ctl;
	logic [tpaf_pkg::DATA_W-1:0] delay_clamped;
	logic [tpaf_pkg::DATA_W-1:0] delay_hi;
	logic                        ch_ok;
	logic [tpaf_pkg::NUM_CHANNELS-1:0] gate_n, fired_n;
	tpaf_pkg::result_t           result_n, result_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			low_limit_q   <= tpaf_pkg::LOW_LIMIT_RST;
			high_limit_q  <= tpaf_pkg::HIGH_LIMIT_RST;
			pulse_width_q <= tpaf_pkg::PULSE_WIDTH_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				tpaf_pkg::REG_LOW_LIMIT:   low_limit_q   <= cfg_data;
				tpaf_pkg::REG_HIGH_LIMIT:  high_limit_q  <= cfg_data;
				tpaf_pkg::REG_PULSE_WIDTH: pulse_width_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign advance   = valid_s1 && free;
	assign req_ready = !valid_s1 || free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req_ready) begin
			valid_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req_ready && req_valid) begin
			cmd_s1      <= cmd;
			channel_s1  <= channel;
			value_s1    <= value;
			ac_level_s1 <= ac_level;
		end
	end

	assign ch_ok = (int'(channel_s1) < tpaf_pkg::NUM_CHANNELS);

	always_comb begin
		ctl = '0;
		case (cmd_s1)
			tpaf_pkg::CMD_TICK:       ctl.tick       = 1'b1;
			tpaf_pkg::CMD_ZERO_CROSS: ctl.zero_cross = !ac_level_s1;
			tpaf_pkg::CMD_SET_DELAY:  ctl.set_delay  = ch_ok;
			tpaf_pkg::CMD_SET_RUN:    ctl.set_run    = ch_ok;
			default: ;
		endcase
	end

	assign delay_hi      = (value_s1 > high_limit_q) ? high_limit_q : value_s1;
	assign delay_clamped = (delay_hi < low_limit_q) ? low_limit_q : delay_hi;

	for (genvar i = 0; i < tpaf_pkg::NUM_CHANNELS; i++) begin : g_lane
		tpaf_lane u_lane (
			.clk         (clk),
			.arst_n      (arst_n),
			.en          (advance),
			.ctl         (ctl),
			.addressed   (int'(channel_s1) == i),
			.delay_in    (delay_clamped),
			.run_in      (value_s1[0]),
			.high_limit  (high_limit_q),
			.pulse_width (pulse_width_q),
			.gate        (gate_n[i]),
			.fired       (fired_n[i])
		);
	end

	always_comb begin
		result_n = '0;
		for (int i = 0; i < tpaf_pkg::OUT_W; i++) begin
			if (i < tpaf_pkg::NUM_CHANNELS) begin
				result_n.gate_bits[i]  = gate_n[i];
				result_n.fired_bits[i] = fired_n[i];
			end
		end
	end

	tpaf_result_reg u_result (
		.clk        (clk),
		.arst_n     (arst_n),
		.load       (valid_s1),
		.result_in  (result_n),
		.free       (free),
		.res_valid  (res_valid),
		.res_ready  (res_ready),
		.result_out (result_q)
	);

	assign gate_bits  = result_q.gate_bits;
	assign fired_bits = result_q.fired_bits;

`ifndef NO_ASSERTIONS
	a_idle_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> req_ready)
		else $error("input register empty but request not ready");

	a_fired_only_on_tick: assert property (@(posedge clk) disable iff (!arst_n)
		advance && (cmd_s1 != tpaf_pkg::CMD_TICK) |=> (fired_bits == '0))
		else $error("fired bits set on a request that is not a tick");

	a_zero_cross_gates_low: assert property (@(posedge clk) disable iff (!arst_n)
		advance && (cmd_s1 == tpaf_pkg::CMD_ZERO_CROSS) && !ac_level_s1
		|=> (gate_bits == '0))
		else $error("gate left high after a zero-cross");

	a_fired_drives_gate: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (pulse_width_q != '0) |-> ((fired_bits & ~gate_bits) == '0))
		else $error("channel fired without raising its gate");
`endif

endmodule
